>>> sv/led_mts_pkg.sv
package led_mts_pkg;

  // Widths fixed by the item fields.
  localparam int unsigned ROW_W    = 8;
  localparam int unsigned ROWS     = 8;
  localparam int unsigned COL_W    = 3;
  localparam int unsigned GLYPH_W  = 4;
  localparam int unsigned CHARS_W  = 6;
  localparam int unsigned HOLD_W   = 16;
  localparam int unsigned CODE_W   = 8;

  localparam logic [HOLD_W-1:0]  HOLD_RESET  = 16'd150;
  localparam logic [GLYPH_W-1:0] BLANK_GLYPH = 4'd15;
  localparam logic [COL_W-1:0]   LAST_COL    = 3'd7;

  // Operation codes of a request.
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_END    = 1'b1;

  // Character codes with a glyph beyond the digits.
  localparam logic [CODE_W-1:0] CODE_DIGIT_0 = 8'h30;
  localparam logic [CODE_W-1:0] CODE_DIGIT_9 = 8'h39;
  localparam logic [CODE_W-1:0] CODE_C       = 8'h43;
  localparam logic [CODE_W-1:0] CODE_H       = 8'h48;
  localparam logic [CODE_W-1:0] CODE_T       = 8'h54;
  localparam logic [CODE_W-1:0] CODE_COLON   = 8'h3A;
  localparam logic [CODE_W-1:0] CODE_DASH    = 8'h2D;

  // Font, one row byte per entry, bit7 is the leftmost column.
  localparam logic [ROW_W-1:0] GLYPH_ROM [16][ROWS] = '{
    '{8'h3C, 8'h42, 8'h81, 8'h81, 8'h81, 8'h81, 8'h42, 8'h3C},
    '{8'h18, 8'h38, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h7E},
    '{8'h7C, 8'h82, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'hFE},
    '{8'h7C, 8'h82, 8'h02, 8'h3C, 8'h02, 8'h02, 8'h82, 8'h7C},
    '{8'h04, 8'h0C, 8'h14, 8'h24, 8'h44, 8'hFE, 8'h04, 8'h04},
    '{8'hFE, 8'h80, 8'h80, 8'hFC, 8'h02, 8'h02, 8'h82, 8'h7C},
    '{8'h3C, 8'h42, 8'h80, 8'hFC, 8'h82, 8'h82, 8'h82, 8'h7C},
    '{8'hFE, 8'h82, 8'h02, 8'h04, 8'h08, 8'h10, 8'h10, 8'h10},
    '{8'h3C, 8'h42, 8'h81, 8'h3C, 8'h81, 8'h81, 8'h42, 8'h3C},
    '{8'h3C, 8'h42, 8'h81, 8'h81, 8'h7D, 8'h01, 8'h02, 8'h3C},
    '{8'h3C, 8'h42, 8'h80, 8'h80, 8'h80, 8'h80, 8'h42, 8'h3C},
    '{8'h81, 8'h81, 8'h81, 8'hFF, 8'h81, 8'h81, 8'h81, 8'h81},
    '{8'hFF, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
    '{8'h00, 8'h00, 8'h18, 8'h18, 8'h00, 8'h18, 8'h18, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // Work passed from the front to the back.
  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic               blank_first;
  } cmd_t;

  typedef logic [ROW_W-1:0] rows_t [ROWS];

  // Maps a character code to its font entry; unknown codes are blank.
  function automatic logic [GLYPH_W-1:0] glyph_index(input logic [CODE_W-1:0] code);
    logic [GLYPH_W-1:0] g;
    g = BLANK_GLYPH;
    if (code >= CODE_DIGIT_0 && code <= CODE_DIGIT_9) begin
      g = GLYPH_W'(code - CODE_DIGIT_0);
    end else begin
      case (code)
        CODE_C:     g = 4'd10;
        CODE_H:     g = 4'd11;
        CODE_T:     g = 4'd12;
        CODE_COLON: g = 4'd13;
        CODE_DASH:  g = 4'd14;
        default:    g = BLANK_GLYPH;
      endcase
    end
    return g;
  endfunction

  // One glyph column, bit r holds the pixel of row r.
  function automatic logic [ROWS-1:0] glyph_column(input logic [GLYPH_W-1:0] g,
                                                   input logic [COL_W-1:0] col);
    logic [ROWS-1:0] c;
    for (int r = 0; r < ROWS; r++) begin
      c[r] = GLYPH_ROM[g][r][LAST_COL - col];
    end
    return c;
  endfunction

endpackage

>>> sv/led_mts_in_if.sv
interface led_mts_in_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [led_mts_pkg::CODE_W-1:0]    char_code;

  modport source (output valid, operation, char_code, input ready);
  modport sink   (input valid, operation, char_code, output ready);
endinterface

>>> sv/led_mts_out_if.sv
interface led_mts_out_if;
  logic                           valid;
  logic                           ready;
  logic [led_mts_pkg::ROW_W-1:0]  row_0;
  logic [led_mts_pkg::ROW_W-1:0]  row_1;
  logic [led_mts_pkg::ROW_W-1:0]  row_2;
  logic [led_mts_pkg::ROW_W-1:0]  row_3;
  logic [led_mts_pkg::ROW_W-1:0]  row_4;
  logic [led_mts_pkg::ROW_W-1:0]  row_5;
  logic [led_mts_pkg::ROW_W-1:0]  row_6;
  logic [led_mts_pkg::ROW_W-1:0]  row_7;
  logic [led_mts_pkg::HOLD_W-1:0] hold_ms;
  logic                           last_frame;

  modport source (output valid, row_0, row_1, row_2, row_3, row_4, row_5, row_6, row_7,
                  hold_ms, last_frame, input ready);
  modport sink   (input valid, row_0, row_1, row_2, row_3, row_4, row_5, row_6, row_7,
                  hold_ms, last_frame, output ready);
endinterface

>>> sv/led_mts_front.sv
module led_mts_front #(
  parameter int unsigned MAX_TEXT_LEN = 32
) (
  input  logic               clk,
  input  logic               rst,
  led_mts_in_if.sink         chars,
  input  logic               q_full,
  output logic               push,
  output led_mts_pkg::cmd_t  cmd
);

  logic                                message_started;
  logic [led_mts_pkg::CHARS_W-1:0]     chars_taken;
  logic                                take;
  logic                                is_end;
  logic                                dropped;

  // A request is taken whenever the queue has room; dropped characters vanish here.
  assign chars.ready = !q_full;
  assign take        = chars.valid && chars.ready;
  assign is_end      = (chars.operation == led_mts_pkg::OP_END);
  assign dropped     = !is_end &&
                       (chars_taken >= led_mts_pkg::CHARS_W'(MAX_TEXT_LEN));
  assign push        = take && !dropped;

  // Classify the request into a glyph and a leading blank frame.
  always_comb begin
    cmd.blank_first = !message_started;
    cmd.glyph       = is_end ? led_mts_pkg::BLANK_GLYPH
                             : led_mts_pkg::glyph_index(chars.char_code);
  end

  // Message bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      message_started <= 1'b0;
      chars_taken     <= '0;
    end else if (push) begin
      if (is_end) begin
        message_started <= 1'b0;
        chars_taken     <= '0;
      end else begin
        message_started <= 1'b1;
        chars_taken     <= chars_taken + 1'b1;
      end
    end
  end

endmodule

>>> sv/led_mts_fifo.sv
module led_mts_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  led_mts_pkg::cmd_t  push_cmd,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output led_mts_pkg::cmd_t  q_cmd
);

  led_mts_pkg::cmd_t  mem [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_cmd   = mem[rd_ptr];

  // Storage for queued commands.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/led_mts_back.sv
module led_mts_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  led_mts_pkg::cmd_t                q_cmd,
  output logic                             pop,
  input  logic [led_mts_pkg::HOLD_W-1:0]   hold_ms,
  led_mts_out_if.source                    frames
);

  logic                             busy;
  logic [led_mts_pkg::GLYPH_W-1:0]  glyph;
  logic                             blank_pending;
  logic [led_mts_pkg::COL_W-1:0]    col;
  led_mts_pkg::rows_t               window;
  led_mts_pkg::rows_t               window_next;
  logic [led_mts_pkg::ROWS-1:0]     column;
  logic                             advance;
  logic                             done;

  led_mts_pkg::rows_t               out_rows;
  logic                             out_valid;
  logic                             out_last;
  logic [led_mts_pkg::HOLD_W-1:0]   out_hold;

  // A frame is made whenever a command is in work and the output register is free or being emptied.
  assign advance = busy && (!out_valid || frames.ready);
  assign done    = advance && !blank_pending && (col == led_mts_pkg::LAST_COL);
  assign pop     = q_valid && (!busy || done);

  // Next window: either cleared for the leading blank frame or shifted by one column.
  assign column = led_mts_pkg::glyph_column(glyph, col);
  always_comb begin
    for (int r = 0; r < led_mts_pkg::ROWS; r++) begin
      window_next[r] = blank_pending ? '0 : {window[r][led_mts_pkg::ROW_W-2:0], column[r]};
    end
  end

  // Command sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      blank_pending <= 1'b0;
      col           <= '0;
    end else if (pop) begin
      busy          <= 1'b1;
      blank_pending <= q_cmd.blank_first;
      col           <= '0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (advance) begin
      if (blank_pending) begin
        blank_pending <= 1'b0;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      glyph <= q_cmd.glyph;
    end
  end

  // Display window.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < led_mts_pkg::ROWS; r++) begin
        window[r] <= '0;
      end
    end else if (advance) begin
      window <= window_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (frames.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rows <= window_next;
      out_last <= !blank_pending && (col == led_mts_pkg::LAST_COL);
      out_hold <= hold_ms;
    end
  end

  assign frames.valid      = out_valid;
  assign frames.row_0      = out_rows[0];
  assign frames.row_1      = out_rows[1];
  assign frames.row_2      = out_rows[2];
  assign frames.row_3      = out_rows[3];
  assign frames.row_4      = out_rows[4];
  assign frames.row_5      = out_rows[5];
  assign frames.row_6      = out_rows[6];
  assign frames.row_7      = out_rows[7];
  assign frames.hold_ms    = out_hold;
  assign frames.last_frame = out_last;

endmodule

>>> sv/led_matrix_text_scroller.sv
// A request is queued, then loaded into the command registers that feed the output register.
// Throughput: one frame per cycle while frames are taken; a request gives 8 frames, 9 when no
// message is open, as the window shifts in one glyph column per frame after the blank one.
// A two-entry command queue lets requests be taken while frames of earlier ones still go out.
// Reset (synchronous, active high) blanks the window, ends any message and sets the dwell to 150.
module led_matrix_text_scroller #(
  parameter int unsigned MAX_TEXT_LEN = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  led_mts_in_if.sink                      chars,
  led_mts_out_if.source                   frames,
  input  logic                            cfg_wr_en,
  input  logic [led_mts_pkg::HOLD_W-1:0]  cfg_wr_data
);

  logic                              push;
  led_mts_pkg::cmd_t                 push_cmd;
  logic                              q_full;
  logic                              pop;
  logic                              q_valid;
  led_mts_pkg::cmd_t                 q_cmd;
  logic [led_mts_pkg::HOLD_W-1:0]    column_dwell_ms;

  // Dwell register.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_dwell_ms <= led_mts_pkg::HOLD_RESET;
    end else if (cfg_wr_en) begin
      column_dwell_ms <= cfg_wr_data;
    end
  end

  led_mts_front #(
    .MAX_TEXT_LEN (MAX_TEXT_LEN)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .q_full (q_full),
    .push   (push),
    .cmd    (push_cmd)
  );

  led_mts_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  led_mts_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .hold_ms (column_dwell_ms),
    .frames  (frames)
  );

endmodule

>>> bench/led_matrix_text_scroller_tb.sv
module led_matrix_text_scroller_tb;

  localparam int unsigned MSG_LIMIT = 32;
  localparam int unsigned RANDOM_REQUESTS = 120;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned FIRST_PREDICTED_ROW = 4;

  // Font used by the scroll predictor, one row byte per entry, bit7 leftmost.
  localparam logic [7:0] FONT [16][8] = '{
    '{8'h3C, 8'h42, 8'h81, 8'h81, 8'h81, 8'h81, 8'h42, 8'h3C},
    '{8'h18, 8'h38, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h7E},
    '{8'h7C, 8'h82, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'hFE},
    '{8'h7C, 8'h82, 8'h02, 8'h3C, 8'h02, 8'h02, 8'h82, 8'h7C},
    '{8'h04, 8'h0C, 8'h14, 8'h24, 8'h44, 8'hFE, 8'h04, 8'h04},
    '{8'hFE, 8'h80, 8'h80, 8'hFC, 8'h02, 8'h02, 8'h82, 8'h7C},
    '{8'h3C, 8'h42, 8'h80, 8'hFC, 8'h82, 8'h82, 8'h82, 8'h7C},
    '{8'hFE, 8'h82, 8'h02, 8'h04, 8'h08, 8'h10, 8'h10, 8'h10},
    '{8'h3C, 8'h42, 8'h81, 8'h3C, 8'h81, 8'h81, 8'h42, 8'h3C},
    '{8'h3C, 8'h42, 8'h81, 8'h81, 8'h7D, 8'h01, 8'h02, 8'h3C},
    '{8'h3C, 8'h42, 8'h80, 8'h80, 8'h80, 8'h80, 8'h42, 8'h3C},
    '{8'h81, 8'h81, 8'h81, 8'hFF, 8'h81, 8'h81, 8'h81, 8'h81},
    '{8'hFF, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
    '{8'h00, 8'h00, 8'h18, 8'h18, 8'h00, 8'h18, 8'h18, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  typedef logic [led_mts_pkg::ROWS-1:0][led_mts_pkg::ROW_W-1:0] win_t;

  typedef struct packed {
    win_t                           rows;
    logic [led_mts_pkg::HOLD_W-1:0] hold_ms;
    logic                           last_frame;
  } frame_t;

  // One directed request; blank_frames >= 0 means the frames are known to be all blank.
  typedef struct {
    logic                           op;
    logic [led_mts_pkg::CODE_W-1:0] code;
    int                             blank_frames;
  } script_row_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_wr_en;
  logic [led_mts_pkg::HOLD_W-1:0] cfg_wr_data;

  led_mts_in_if  chars_if ();
  led_mts_out_if frames_if ();

  led_matrix_text_scroller #(
    .MAX_TEXT_LEN(MSG_LIMIT)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .chars(chars_if),
    .frames(frames_if),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Shadow state of the scroller.
  win_t                            win_rows;
  logic                            msg_open;
  logic [led_mts_pkg::CHARS_W-1:0] msg_chars;
  logic [led_mts_pkg::HOLD_W-1:0]  dwell_ms;

  frame_t pending_frames [$];

  int errors = 0;
  int n_requests = 0;
  int n_dropped = 0;
  int n_frames = 0;
  int n_dwell_writes = 0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Timeout at %0t with %0d frames still awaited.", $time, pending_frames.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // Font slot of a character code; anything outside the font is the blank slot.
  function automatic logic [led_mts_pkg::GLYPH_W-1:0] font_slot(
      input logic [led_mts_pkg::CODE_W-1:0] code);
    if (code >= led_mts_pkg::CODE_DIGIT_0 && code <= led_mts_pkg::CODE_DIGIT_9) begin
      return led_mts_pkg::GLYPH_W'(code - led_mts_pkg::CODE_DIGIT_0);
    end
    case (code)
      led_mts_pkg::CODE_C:     return 4'd10;
      led_mts_pkg::CODE_H:     return 4'd11;
      led_mts_pkg::CODE_T:     return 4'd12;
      led_mts_pkg::CODE_COLON: return 4'd13;
      led_mts_pkg::CODE_DASH:  return 4'd14;
      default:                 return led_mts_pkg::BLANK_GLYPH;
    endcase
  endfunction

  // Works out the frames a request scrolls out and advances the shadow state.
  function automatic void scroll_frames(input logic op,
                                        input logic [led_mts_pkg::CODE_W-1:0] code,
                                        output frame_t frames_out [$]);
    logic [led_mts_pkg::GLYPH_W-1:0] slot;
    frame_t                          f;
    frames_out = {};
    if (op == led_mts_pkg::OP_APPEND && msg_chars >= MSG_LIMIT) begin
      return;
    end
    if (!msg_open) begin
      win_rows = '0;
      f.rows = win_rows;
      f.hold_ms = dwell_ms;
      f.last_frame = 1'b0;
      frames_out.push_back(f);
      msg_open = 1'b1;
    end
    slot = (op == led_mts_pkg::OP_APPEND) ? font_slot(code) : led_mts_pkg::BLANK_GLYPH;
    for (int col = 0; col < 8; col++) begin
      for (int r = 0; r < led_mts_pkg::ROWS; r++) begin
        win_rows[r] = {win_rows[r][led_mts_pkg::ROW_W-2:0], FONT[slot][r][7 - col]};
      end
      f.rows = win_rows;
      f.hold_ms = dwell_ms;
      f.last_frame = (col == 7);
      frames_out.push_back(f);
    end
    if (op == led_mts_pkg::OP_APPEND) begin
      msg_chars = msg_chars + 1'b1;
    end else begin
      msg_open = 1'b0;
      msg_chars = '0;
    end
  endfunction

  // Offers one request in bursts with random gaps, then records its frames.
  task automatic send_req(input logic op, input logic [led_mts_pkg::CODE_W-1:0] code,
                          input int blank_frames);
    int     gap;
    frame_t predicted [$];
    frame_t f;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        chars_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    chars_if.valid <= 1'b1;
    chars_if.operation <= op;
    chars_if.char_code <= code;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    burst_left--;
    scroll_frames(op, code, predicted);
    if (predicted.size() == 0) begin
      n_dropped++;
    end else begin
      n_requests++;
    end
    if (blank_frames >= 0) begin
      // Frames typed in by hand: all blank, last flag on the final one.
      for (int k = 0; k < blank_frames; k++) begin
        f.rows = '0;
        f.hold_ms = dwell_ms;
        f.last_frame = (k == blank_frames - 1);
        pending_frames.push_back(f);
      end
    end else begin
      foreach (predicted[k]) pending_frames.push_back(predicted[k]);
    end
  endtask

  // Holds the sender until every frame is out and the block has gone quiet.
  task automatic drain();
    chars_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dwell(input logic [led_mts_pkg::HOLD_W-1:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    dwell_ms = value;
    n_dwell_writes++;
  endtask

  function automatic logic [led_mts_pkg::CODE_W-1:0] random_code();
    int k;
    if ($urandom_range(0, 9) < 7) begin
      k = $urandom_range(0, 14);
      case (k)
        10:      return led_mts_pkg::CODE_C;
        11:      return led_mts_pkg::CODE_H;
        12:      return led_mts_pkg::CODE_T;
        13:      return led_mts_pkg::CODE_COLON;
        14:      return led_mts_pkg::CODE_DASH;
        default: return led_mts_pkg::CODE_DIGIT_0 + led_mts_pkg::CODE_W'(k);
      endcase
    end
    return led_mts_pkg::CODE_W'($urandom_range(0, 255));
  endfunction

  // Receiver stall pattern: a new mode is drawn each time stall_cnt wraps.
  logic [7:0] stall_cnt;
  logic [1:0] stall_mode;

  always @(posedge clk) begin
    if (rst) begin
      stall_cnt <= '0;
      stall_mode <= '0;
      frames_if.ready <= 1'b0;
    end else begin
      stall_cnt <= (stall_cnt == 8'd47) ? '0 : stall_cnt + 1'b1;
      if (stall_cnt == 8'd47) begin
        stall_mode <= 2'($urandom_range(0, 3));
      end
      case (stall_mode)
        2'd0: frames_if.ready <= 1'b1;
        2'd1: frames_if.ready <= 1'($urandom_range(0, 1));
        2'd2: frames_if.ready <= (stall_cnt[1:0] == 2'd0);
        default: frames_if.ready <= ~stall_cnt[2];
      endcase
    end
  end

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val !== act_val) begin
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $time, name, exp_val,
               act_val);
      errors++;
    end
  endtask

  // Compares every accepted frame with the oldest one awaited.
  always @(posedge clk) begin
    frame_t want;
    win_t   got_rows;
    if (!rst && frames_if.valid && frames_if.ready) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: frame arrived with none awaited", $time);
        errors++;
      end else begin
        want = pending_frames.pop_front();
        got_rows = {frames_if.row_7, frames_if.row_6, frames_if.row_5, frames_if.row_4,
                    frames_if.row_3, frames_if.row_2, frames_if.row_1, frames_if.row_0};
        for (int r = 0; r < led_mts_pkg::ROWS; r++) begin
          check_field($sformatf("row_%0d", r), want.rows[r], got_rows[r]);
        end
        check_field("hold_ms", want.hold_ms, frames_if.hold_ms);
        check_field("last_frame", want.last_frame, frames_if.last_frame);
        n_frames++;
      end
    end
  end

  initial begin
    script_row_t script [22];
    int          sent;
    int          msg_idx;
    int          msg_len;
    int          pick;

    script = '{
      '{led_mts_pkg::OP_END,    8'hA5,                     9},   // end, no message open
      '{led_mts_pkg::OP_APPEND, 8'h00,                     9},   // unknown code opens
      '{led_mts_pkg::OP_APPEND, 8'hFF,                     8},   // unknown code inside
      '{led_mts_pkg::OP_END,    8'h00,                     8},   // end after blanks
      '{led_mts_pkg::OP_APPEND, led_mts_pkg::CODE_DIGIT_0, -1},
      '{led_mts_pkg::OP_APPEND, 8'h31,                     -1},
      '{led_mts_pkg::OP_APPEND, 8'h32,                     -1},
      '{led_mts_pkg::OP_APPEND, 8'h33,                     -1},
      '{led_mts_pkg::OP_APPEND, 8'h34,                     -1},
      '{led_mts_pkg::OP_APPEND, 8'h35,                     -1},
      '{led_mts_pkg::OP_APPEND, 8'h36,                     -1},
      '{led_mts_pkg::OP_APPEND, 8'h37,                     -1},
      '{led_mts_pkg::OP_APPEND, 8'h38,                     -1},
      '{led_mts_pkg::OP_APPEND, led_mts_pkg::CODE_DIGIT_9, -1},
      '{led_mts_pkg::OP_APPEND, led_mts_pkg::CODE_C,       -1},
      '{led_mts_pkg::OP_APPEND, led_mts_pkg::CODE_H,       -1},
      '{led_mts_pkg::OP_APPEND, led_mts_pkg::CODE_T,       -1},
      '{led_mts_pkg::OP_APPEND, led_mts_pkg::CODE_COLON,   -1},
      '{led_mts_pkg::OP_APPEND, led_mts_pkg::CODE_DASH,    -1},
      '{led_mts_pkg::OP_APPEND, 8'h20,                     -1},
      '{led_mts_pkg::OP_APPEND, 8'h41,                     -1},
      '{led_mts_pkg::OP_END,    8'hFF,                     -1}
    };

    // Known values on every input from the start.
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    chars_if.valid <= 1'b0;
    chars_if.operation <= led_mts_pkg::OP_APPEND;
    chars_if.char_code <= '0;
    win_rows = '0;
    msg_open = 1'b0;
    msg_chars = '0;
    dwell_ms = led_mts_pkg::HOLD_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part: blank cases at the reset dwell, then every glyph at the top dwell.
    foreach (script[i]) begin
      if (i == FIRST_PREDICTED_ROW) begin
        write_dwell(16'hFFFF);
      end
      send_req(script[i].op, script[i].code, script[i].blank_frames);
    end
    write_dwell(16'h0000);

    // Random messages; a few run past the length limit so that characters get dropped.
    sent = 0;
    msg_idx = 0;
    while (sent < RANDOM_REQUESTS) begin
      if (msg_idx == 1) begin
        msg_len = $urandom_range(MSG_LIMIT + 1, MSG_LIMIT + 3);
      end else if ($urandom_range(0, 7) == 0) begin
        msg_len = $urandom_range(MSG_LIMIT - 4, MSG_LIMIT + 4);
      end else begin
        msg_len = $urandom_range(0, 6);
      end
      for (int c = 0; c < msg_len; c++) begin
        if (msg_chars < MSG_LIMIT) begin
          sent++;
        end
        send_req(led_mts_pkg::OP_APPEND, random_code(), -1);
      end
      // Now and then a message is left open and runs into the next one.
      if ($urandom_range(0, 9) != 0) begin
        send_req(led_mts_pkg::OP_END, led_mts_pkg::CODE_W'($urandom_range(0, 255)), -1);
        sent++;
      end
      msg_idx++;
      if (msg_idx % 4 == 0) begin
        pick = $urandom_range(0, 2);
        case (pick)
          0:       write_dwell(16'h0000);
          1:       write_dwell(16'hFFFF);
          default: write_dwell(led_mts_pkg::HOLD_W'($urandom_range(0, 65535)));
        endcase
      end
    end

    drain();
    $display("Checked %0d frames from %0d requests over %0d dwell settings.", n_frames,
             n_requests, n_dwell_writes + 1);
    $display("Characters dropped past the length limit: %0d.", n_dropped);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
